// ===== src/text_console_glyph_writer_unit_macros.svh =====
// Assertion helpers for the glyph writer; all are clocked on clk and idle during reset.
`ifndef TEXT_CONSOLE_GLYPH_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_WRITER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TCGW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCGW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcgw_pkg.sv =====
package tcgw_pkg;

  // Microcode step addresses
  typedef logic [2:0] step_t;

  localparam step_t S_CLR      = 3'd0;
  localparam step_t S_CLR_DONE = 3'd1;
  localparam step_t S_IDLE     = 3'd2;
  localparam step_t S_DECODE   = 3'd3;
  localparam step_t S_ROUTE    = 3'd4;
  localparam step_t S_EMIT1    = 3'd5;
  localparam step_t S_PRIME    = 3'd6;
  localparam step_t S_PAINT    = 3'd7;

  // Branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR_MORE,
    C_PEND,
    C_ACCEPT,
    C_PAINT,
    C_CLEAR,
    C_LAST_LINE
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  decode;
    logic  clr;
    logic  prime;
    logic  paint;
    logic  emit1;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ucode_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_WRAP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] ACT_AT_CURSOR = 2'd0;
  localparam logic [1:0] ACT_AT_CELL   = 2'd1;
  localparam logic [1:0] ACT_FONT_LOAD = 2'd2;

  localparam logic [6:0] CH_BS   = 7'd8;
  localparam logic [6:0] CH_TAB  = 7'd9;
  localparam logic [6:0] CH_NL   = 7'd10;
  localparam logic [6:0] CH_FF   = 7'd12;
  localparam logic [6:0] CH_CR   = 7'd13;
  localparam logic [6:0] CH_SKIP = 7'd95;

  localparam logic [2:0] LAST_LINE = 3'd7;

  // Control store: one word per step, true and false branch targets.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '0;
    case (s)
      S_CLR: begin
        w.clr = 1'b1; w.cond = C_CLR_MORE; w.jt = S_CLR; w.jf = S_CLR_DONE;
      end
      S_CLR_DONE: begin
        w.cond = C_PEND; w.jt = S_EMIT1; w.jf = S_IDLE;
      end
      S_IDLE: begin
        w.accept = 1'b1; w.cond = C_ACCEPT; w.jt = S_DECODE; w.jf = S_IDLE;
      end
      S_DECODE: begin
        w.decode = 1'b1; w.cond = C_PAINT; w.jt = S_PRIME; w.jf = S_ROUTE;
      end
      S_ROUTE: begin
        w.cond = C_CLEAR; w.jt = S_CLR; w.jf = S_EMIT1;
      end
      S_EMIT1: begin
        w.emit1 = 1'b1; w.cond = C_ALWAYS; w.jt = S_IDLE; w.jf = S_IDLE;
      end
      S_PRIME: begin
        w.prime = 1'b1; w.cond = C_ALWAYS; w.jt = S_PAINT; w.jf = S_PAINT;
      end
      S_PAINT: begin
        w.paint = 1'b1; w.cond = C_LAST_LINE; w.jt = S_IDLE; w.jf = S_PAINT;
      end
      default: begin
        w.cond = C_ALWAYS; w.jt = S_IDLE; w.jf = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/text_console_glyph_writer_unit.sv =====
// Text console glyph writer.
// Input channel (in_valid / in_stall) takes one word per item: draw a character at
// the cursor, draw at a given text cell, or load one row of the 8x8 font.
// Output channel (out_valid / out_stall) returns result words from a single output
// register; items that draw or erase a cell give eight words (one per pixel line, top first), all
// other items give one. out_last marks the final word of an item.
// Sequence: a drawn or erased cell is accepted, decoded and primed, then painted one
// pixel line per step, one word per cycle while out_stall stays low; the next item
// can be taken once the last line is painted. Single-word items go through the
// accept, decode, route and emit steps. Each pixel line is one read-modify-write
// of the frame memory, overlapped with the read of the next line.
// A control code that runs off the bottom clears the screen: the sequencer sweeps
// the frame memory one word per cycle (TEXT_ROWS*8*WPL words, 4736 by default)
// before the one result word leaves.
// Reset (rst_n low, synchronous) homes the cursor and starts the same sweep;
// in_stall stays high until the sweep is done. The font is not cleared.
// While out_stall is high the output word holds and the sequencer halts at the
// next emitting step; a new item is still taken while the last word waits.
`include "text_console_glyph_writer_unit_macros.svh"
module text_console_glyph_writer_unit
  import tcgw_pkg::*;
#(
  parameter int TEXT_COLS   = 64,
  parameter int TEXT_ROWS   = 37,
  parameter int GLYPH_COUNT = 128,
  parameter int TAB_STEP    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_char_code,
  input  logic [5:0]  in_text_row,
  input  logic [6:0]  in_text_col,
  input  logic [2:0]  in_glyph_row,
  input  logic [7:0]  in_glyph_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_write_valid,
  output logic [12:0] out_word_address,
  output logic [31:0] out_word_data,
  output logic        out_screen_cleared,
  output logic [5:0]  out_cursor_row,
  output logic [5:0]  out_cursor_col,
  output logic        out_last
);

  // Geometry
  localparam int WPL         = (TEXT_COLS + 3) / 4;
  localparam int FRAME_WORDS = TEXT_ROWS * 8 * WPL;
  localparam int FONT_BYTES  = GLYPH_COUNT * 8;
  localparam int AW          = $clog2(FRAME_WORDS);
  localparam int GW          = $clog2(GLYPH_COUNT);
  localparam int FAW         = GW + 3;
  localparam int RW          = $clog2(TEXT_ROWS + 1);
  localparam int CCW         = $clog2(TEXT_COLS);
  localparam int CW          = $clog2(TEXT_COLS + TAB_STEP);

  localparam logic [RW-1:0]  ROWS_L   = RW'(TEXT_ROWS);
  localparam logic [CW-1:0]  COLS_L   = CW'(TEXT_COLS);
  localparam logic [CCW-1:0] LAST_COL = CCW'(TEXT_COLS - 1);
  localparam logic [CW-1:0]  TAB_L    = CW'(TAB_STEP);
  localparam logic [AW-1:0]  STRIDE   = AW'(8 * WPL);
  localparam logic [AW-1:0]  WPL_L    = AW'(WPL);
  localparam logic [AW-1:0]  CLR_LAST = AW'(FRAME_WORDS - 1);

  typedef enum logic [1:0] {K_SINGLE, K_PAINT, K_CLEAR} kind_t;

  // Memories
  logic [31:0] frame_mem [FRAME_WORDS];
  logic [7:0]  font_mem  [FONT_BYTES];

  // Sequencer
  step_t  step_r;
  ucode_t cw;
  logic   take;
  logic   advance;
  logic   out_free;

  // Held input word
  logic [1:0] act_r;
  logic [6:0] code_r;
  logic [5:0] trow_r;
  logic [6:0] tcol_r;
  logic [2:0] grow_r;
  logic [7:0] gbits_r;

  // Cursor and decoded item
  logic [RW-1:0]  cur_row_r;
  logic [CCW-1:0] cur_col_r;
  kind_t          kind_r;
  logic [1:0]     status_r;
  logic           cleared_r;
  logic           erase_r;
  logic [GW-1:0]  glyph_r;
  logic [1:0]     lane_r;
  logic           pend_r;

  // Paint datapath
  logic [AW-1:0] la_r;
  logic [AW-1:0] wa_r;
  logic [2:0]    line_r;
  logic [AW-1:0] clr_r;
  logic [31:0]   fr_rd_r;
  logic [7:0]    font_rd_r;

  // Output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_write_valid_r;
  logic [12:0] out_word_address_r;
  logic [31:0] out_word_data_r;
  logic        out_screen_cleared_r;
  logic [5:0]  out_cursor_row_r;
  logic [5:0]  out_cursor_col_r;
  logic        out_last_r;

  // Decode
  logic           reject;
  logic [RW-1:0]  base_row;
  logic [CCW-1:0] base_col;
  logic [RW-1:0]  row_inc;
  logic [CW-1:0]  col_step;
  logic           off;
  kind_t          dec_kind;
  logic [1:0]     dec_status;
  logic           dec_cleared;
  logic           dec_erase;
  logic           dec_font_we;
  logic [RW-1:0]  dec_prow;
  logic [CCW-1:0] dec_pcol;
  logic [RW-1:0]  dec_row;
  logic [CCW-1:0] dec_col;
  logic [AW-1:0]  dec_base;

  // Memory ports and merge
  logic          fr_we;
  logic [AW-1:0] fr_waddr;
  logic [31:0]   fr_wdata;
  logic          rd_en;
  logic [FAW-1:0] font_raddr;
  logic [4:0]    shift;
  logic [31:0]   lane_mask;
  logic [7:0]    glyph_byte;
  logic [31:0]   merged;

  assign cw       = ucode_rom(step_r);
  assign in_stall = !cw.accept;
  assign out_free = !out_valid_r || !out_stall;
  // Emitting steps halt while the output word is still waiting.
  assign advance  = !(cw.paint || cw.emit1) || out_free;

  always_comb begin
    case (cw.cond)
      C_ALWAYS:    take = 1'b1;
      C_CLR_MORE:  take = (clr_r != CLR_LAST);
      C_PEND:      take = pend_r;
      C_ACCEPT:    take = in_valid;
      C_PAINT:     take = (dec_kind == K_PAINT);
      C_CLEAR:     take = (kind_r == K_CLEAR);
      C_LAST_LINE: take = (line_r == LAST_LINE);
      default:     take = 1'b0;
    endcase
  end

  // Cell selection and cursor motion for one character.
  assign reject = (act_r == ACT_AT_CELL) &&
                  (({1'b0, trow_r} >= 7'(TEXT_ROWS)) || ({1'b0, tcol_r} >= 8'(TEXT_COLS)));
  assign base_row = (act_r == ACT_AT_CELL) ? RW'(trow_r) : cur_row_r;
  assign base_col = (act_r == ACT_AT_CELL) ? CCW'(tcol_r) : cur_col_r;
  assign row_inc  = base_row + 1'b1;
  assign col_step = CW'(base_col) + ((code_r == CH_TAB) ? TAB_L : CW'(1));

  always_comb begin
    dec_kind    = K_SINGLE;
    dec_status  = ST_OK;
    dec_cleared = 1'b0;
    dec_erase   = 1'b0;
    dec_font_we = 1'b0;
    dec_prow    = base_row;
    dec_pcol    = base_col;
    dec_row     = cur_row_r;
    dec_col     = cur_col_r;
    off         = 1'b0;
    case (act_r)
      ACT_AT_CURSOR, ACT_AT_CELL: begin
        if (reject) begin
          dec_status = ST_REJECT;
        end else begin
          dec_row = base_row;
          dec_col = base_col;
          case (code_r)
            CH_NL: begin
              dec_row = row_inc;
              dec_col = '0;
              off     = (row_inc >= ROWS_L);
            end
            CH_CR: begin
              dec_col = '0;
            end
            CH_FF: begin
              dec_row = row_inc;
              off     = (row_inc >= ROWS_L);
            end
            CH_TAB, CH_SKIP: begin
              if (col_step >= COLS_L) begin
                dec_row = row_inc;
                dec_col = '0;
                off     = (row_inc >= ROWS_L);
              end else begin
                dec_col = CCW'(col_step);
              end
            end
            CH_BS: begin
              // Step back, then erase the cell now under the cursor; no-op at home.
              if (base_col == '0) begin
                if (base_row != '0) begin
                  dec_row   = base_row - 1'b1;
                  dec_col   = LAST_COL;
                  dec_prow  = base_row - 1'b1;
                  dec_pcol  = LAST_COL;
                  dec_kind  = K_PAINT;
                  dec_erase = 1'b1;
                end
              end else begin
                dec_col   = base_col - 1'b1;
                dec_pcol  = base_col - 1'b1;
                dec_kind  = K_PAINT;
                dec_erase = 1'b1;
              end
            end
            default: begin
              dec_kind = K_PAINT;
              if (col_step >= COLS_L) begin
                dec_col = '0;
                if (row_inc >= ROWS_L) begin
                  dec_row    = '0;
                  dec_status = ST_WRAP;
                end else begin
                  dec_row = row_inc;
                end
              end else begin
                dec_col = CCW'(col_step);
              end
            end
          endcase
          if (off) begin
            dec_kind    = K_CLEAR;
            dec_status  = ST_WRAP;
            dec_cleared = 1'b1;
            dec_row     = '0;
            dec_col     = '0;
          end
        end
      end
      ACT_FONT_LOAD: dec_font_we = 1'b1;
      default: ;
    endcase
  end

  assign dec_base = AW'(dec_prow) * STRIDE + AW'(dec_pcol >> 2);

  // Lane merge: column 0 of a word sits in the top byte.
  assign shift      = {2'(2'd3 - lane_r), 3'b000};
  assign lane_mask  = 32'h0000_00FF << shift;
  assign glyph_byte = erase_r ? 8'h00 : font_rd_r;
  assign merged     = (fr_rd_r & ~lane_mask) | ({24'h00_0000, glyph_byte} << shift);

  assign fr_we      = cw.clr || (cw.paint && advance);
  assign fr_waddr   = cw.clr ? clr_r : wa_r;
  assign fr_wdata   = cw.clr ? 32'h0000_0000 : merged;
  // Fetch the next line on prime and on each advancing paint step; the last line fetches nothing.
  assign rd_en      = cw.prime || (cw.paint && advance && (line_r != LAST_LINE));
  assign font_raddr = cw.prime ? {glyph_r, 3'd0} : {glyph_r, 3'(line_r + 3'd1)};

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= fr_wdata;
    end
    if (rd_en) begin
      fr_rd_r <= frame_mem[la_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cw.decode && dec_font_we) begin
      font_mem[{GW'(code_r), grow_r}] <= gbits_r;
    end
    if (rd_en) begin
      font_rd_r <= font_mem[font_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
    end else begin
      if (advance) begin
        step_r <= take ? cw.jt : cw.jf;
      end
      // Drop the output word once taken, unless an emit below reloads it.
      if (!out_stall && !((cw.paint || cw.emit1) && advance)) begin
        out_valid_r <= 1'b0;
      end
      // Hold the accepted input word.
      if (cw.accept && in_valid) begin
        act_r   <= in_action;
        code_r  <= in_char_code;
        trow_r  <= in_text_row;
        tcol_r  <= in_text_col;
        grow_r  <= in_glyph_row;
        gbits_r <= in_glyph_bits;
      end
      if (cw.decode) begin
        cur_row_r <= dec_row;
        cur_col_r <= dec_col;
        kind_r    <= dec_kind;
        status_r  <= dec_status;
        cleared_r <= dec_cleared;
        erase_r   <= dec_erase;
        glyph_r   <= GW'(code_r);
        lane_r    <= dec_pcol[1:0];
        la_r      <= dec_base;
        line_r    <= '0;
        pend_r    <= 1'b1;
      end
      if (cw.clr) begin
        clr_r <= (clr_r != CLR_LAST) ? clr_r + 1'b1 : '0;
      end
      if (cw.prime) begin
        wa_r <= la_r;
        la_r <= la_r + WPL_L;
      end
      if (cw.paint && advance) begin
        wa_r                 <= la_r;
        la_r                 <= la_r + WPL_L;
        line_r               <= line_r + 1'b1;
        out_valid_r          <= 1'b1;
        out_status_r         <= status_r;
        out_write_valid_r    <= 1'b1;
        out_word_address_r   <= 13'(wa_r);
        out_word_data_r      <= merged;
        out_screen_cleared_r <= cleared_r;
        out_cursor_row_r     <= 6'(cur_row_r);
        out_cursor_col_r     <= 6'(cur_col_r);
        out_last_r           <= (line_r == LAST_LINE);
        if (line_r == LAST_LINE) begin
          pend_r <= 1'b0;
        end
      end
      if (cw.emit1 && advance) begin
        out_valid_r          <= 1'b1;
        out_status_r         <= status_r;
        out_write_valid_r    <= 1'b0;
        out_word_address_r   <= '0;
        out_word_data_r      <= '0;
        out_screen_cleared_r <= cleared_r;
        out_cursor_row_r     <= 6'(cur_row_r);
        out_cursor_col_r     <= 6'(cur_col_r);
        out_last_r           <= 1'b1;
        pend_r               <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_write_valid    = out_write_valid_r;
  assign out_word_address   = out_word_address_r;
  assign out_word_data      = out_word_data_r;
  assign out_screen_cleared = out_screen_cleared_r;
  assign out_cursor_row     = out_cursor_row_r;
  assign out_cursor_col     = out_cursor_col_r;
  assign out_last           = out_last_r;

  `TCGW_ASSERT_NOW(a_accept_not_busy, in_valid && !in_stall, !pend_r, "item taken while busy")
  `TCGW_ASSERT_NEXT(a_decode_after_accept, in_valid && !in_stall, step_r == S_DECODE,
    "accepted item not decoded")
  `TCGW_ASSERT_NOW(a_cursor_in_range, 1'b1,
    (cur_row_r < ROWS_L) && (CW'(cur_col_r) < COLS_L), "cursor off screen")
  `TCGW_ASSERT_NOW(a_multi_word_writes, out_valid && !out_last, out_write_valid,
    "non-final word without write")

endmodule
